// ===== hw/rtl/pli_pkg.sv =====
// shared types and constants for the polyline intersection block
package pli_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned WideW  = 68;
  localparam logic [CoordW:0] VertEps = 33'd7;

  typedef enum logic [1:0] {
    REG_QSX = 2'd0,
    REG_QSY = 2'd1,
    REG_QEX = 2'd2,
    REG_QEY = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                  hit;
    logic [15:0]           segment_index;
    logic [16:0]           fraction;
    logic signed [31:0]    cross_x;
    logic signed [31:0]    cross_y;
    logic                  list_end;
  } result_t;
endpackage

// ===== hw/rtl/pli_if.sv =====
// valid/ready channel interfaces
interface pli_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               first_point;
  logic               final_point;
  modport source (output valid, point_x, point_y, first_point, final_point, input ready);
  modport sink   (input valid, point_x, point_y, first_point, final_point, output ready);
endinterface

interface pli_result_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [15:0]        segment_index;
  logic [16:0]        fraction;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_y;
  logic               list_end;
  modport source (output valid, hit, segment_index, fraction, cross_x, cross_y, list_end,
                  input ready);
  modport sink   (input valid, hit, segment_index, fraction, cross_x, cross_y, list_end,
                  output ready);
endinterface

interface pli_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pli_mul.sv =====
// bit-serial signed multiplier, one multiplier bit per cycle
module pli_mul #(
  parameter int unsigned AW = 34,
  parameter int unsigned BW = 34
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic                    done,
  output logic signed [AW+BW-1:0] prod
);
  localparam int unsigned CW = $clog2(BW + 1);
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic signed [AW+BW-1:0] mcand;
  logic [BW-1:0]           mplier;
  logic signed [AW+BW-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        mcand  <= (AW+BW)'(a);
        mplier <= b;
        acc    <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          if (cnt == CW'(BW - 1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    prod = acc;
    if (done) prod = acc;
  end
endmodule

// ===== hw/rtl/pli_div.sv =====
// restoring divider producing floor(n * 2^QB / d) for 0 <= n <= d, one bit per cycle
module pli_div #(
  parameter int unsigned W  = 68,
  parameter int unsigned QB = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  output logic          done,
  output logic [QB:0]   quo
);
  localparam int unsigned CW = $clog2(QB + 2);
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    rem;
  logic [W:0]    dsr;
  logic [W:0]    diff;

  assign diff = rem - dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= {1'b0, num};
        dsr  <= {1'b0, den};
        quo  <= '0;
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= {diff[W-1:0], 1'b0};
          quo <= {quo[QB-1:0], 1'b1};
        end else begin
          rem <= {rem[W-1:0], 1'b0};
          quo <= {quo[QB-1:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QB)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/polyline_line_intersection.sv =====
// polyline against query segment intersection, top level
// paths from vertex beat to result: no segment or a box miss goes straight to the output state,
// a vertical query skips the products, a general query forms them first, a hit adds divide and scale
// serial multiplier: six products for the general test and two for the point
// one vertex at a time; next vertex taken the cycle after the result beat or the return to idle
// rst clears the query registers, previous vertex, segment counter and output valid
module polyline_line_intersection #(
  parameter int unsigned MAX_SEGMENTS  = 65536,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  pli_cfg_if.sink       cfg,
  pli_point_if.sink     pin,
  pli_result_if.source  rout
);
  localparam int unsigned W  = pli_pkg::WideW;
  localparam int unsigned SC = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned QB = FRACTION_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_BOX, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_CHK, S_DIV, S_SX, S_SY, S_OUT
  } state_t;

  state_t state;
  logic signed [31:0] qsx, qsy, qex, qey;
  logic signed [31:0] prev_x, prev_y, cur_x, cur_y;
  logic               have_prev, last;
  logic [SC-1:0]      seg_cnt;
  logic [15:0]        idx;
  logic               vq;
  logic signed [W-1:0] n, d, t, p0;
  logic [QB:0]        q;

  // bounding box and difference logic
  logic signed [33:0] dxa, dya, dxb, dyb, ex, ey, lo, hi, dqx;
  logic signed [32:0] mnxb, mxxb, mnyb, mxyb, mnxa, mxxa, mnya, mxya;
  logic               box_miss, vb, vqa;

  always_comb begin
    dxa = 34'(qex) - 34'(qsx);
    dya = 34'(qey) - 34'(qsy);
    dxb = 34'(cur_x) - 34'(prev_x);
    dyb = 34'(cur_y) - 34'(prev_y);
    ex  = 34'(prev_x) - 34'(qsx);
    ey  = 34'(prev_y) - 34'(qsy);
    dqx = 34'(qsx) - 34'(prev_x);
    mnxb = 33'((prev_x < cur_x) ? prev_x : cur_x);
    mxxb = 33'((prev_x < cur_x) ? cur_x : prev_x);
    mnyb = 33'((prev_y < cur_y) ? prev_y : cur_y);
    mxyb = 33'((prev_y < cur_y) ? cur_y : prev_y);
    mnxa = 33'((qsx < qex) ? qsx : qex);
    mxxa = 33'((qsx < qex) ? qex : qsx);
    mnya = 33'((qsy < qey) ? qsy : qey);
    mxya = 33'((qsy < qey) ? qey : qsy);
    box_miss = (mnxb > mxxa) || (mxxb < mnxa) || (mnyb > mxya) || (mxyb < mnya);
    vqa = ((dxa < 0) ? -dxa : dxa) < 34'(pli_pkg::VertEps);
    vb  = ((dxb < 0) ? -dxb : dxb) < 34'(pli_pkg::VertEps);
    lo = 34'((mnya > mnyb) ? mnya : mnyb);
    hi = 34'((mxya < mxyb) ? mxya : mxyb);
  end

  // shared serial multiplier
  logic               m_start, m_done;
  logic signed [33:0] ma, mb;
  logic signed [67:0] m_prod;
  pli_mul #(.AW(34), .BW(34)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(ma), .b(mb), .done(m_done), .prod(m_prod)
  );

  logic          dv_start, dv_done;
  logic [W-1:0]  an, ad;
  pli_div #(.W(W), .QB(QB)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(an), .den(ad), .done(dv_done), .quo(q)
  );
  assign an = n[W-1] ? W'(-n) : W'(n);
  assign ad = d[W-1] ? W'(-d) : W'(d);

  function automatic logic in_unit(logic signed [W-1:0] nn, logic signed [W-1:0] dd);
    logic [W-1:0] a0, b0;
    a0 = nn[W-1] ? W'(-nn) : W'(nn);
    b0 = dd[W-1] ? W'(-dd) : W'(dd);
    if (dd == '0) return 1'b0;
    if (nn == '0) return 1'b1;
    if (nn[W-1] != dd[W-1]) return 1'b0;
    return a0 <= b0;
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_M0: begin ma = ex;  mb = dya; end
      S_M1: begin ma = ey;  mb = dxa; end
      S_M2: begin ma = dxa; mb = dyb; end
      S_M3: begin ma = dya; mb = dxb; end
      S_M4: begin ma = ex;  mb = dyb; end
      S_M5: begin ma = ey;  mb = dxb; end
      S_SX: begin ma = dxb; mb = 34'($unsigned(q)); end
      S_SY: begin ma = dyb; mb = 34'($unsigned(q)); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic [SC:0]   cnt_inc;
  logic [67:0]   sc_pos;
  logic signed [67:0] sc;
  assign cnt_inc = {1'b0, seg_cnt} + 1'b1;
  assign sc_pos  = m_prod[67] ? 68'(-m_prod) : 68'(m_prod);
  always_comb begin
    if (!m_prod[67]) sc = 68'(sc_pos >> QB);
    else sc = -68'((sc_pos + 68'((69'd1 << QB) - 1)) >> QB);
  end

  logic        r_valid, r_hit, go;
  logic [16:0] r_frac;
  logic signed [31:0] r_cx, r_cy;

  assign cfg.ready = (state == S_IDLE);
  assign pin.ready = (state == S_IDLE) && !r_valid;
  assign rout.valid = r_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      qsx <= '0; qsy <= '0; qex <= '0; qey <= '0;
      prev_x <= '0; prev_y <= '0;
      have_prev <= 1'b0;
      seg_cnt <= '0;
      r_valid <= 1'b0;
      m_start <= 1'b0;
      dv_start <= 1'b0;
    end else begin
      m_start  <= 1'b0;
      dv_start <= 1'b0;
      if (r_valid && rout.ready) r_valid <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        unique case (pli_pkg::reg_index_t'(cfg.index))
          pli_pkg::REG_QSX: qsx <= cfg.data;
          pli_pkg::REG_QSY: qsy <= cfg.data;
          pli_pkg::REG_QEX: qex <= cfg.data;
          pli_pkg::REG_QEY: qey <= cfg.data;
        endcase
      end
      unique case (state)
        S_IDLE: if (pin.valid && pin.ready) begin
          cur_x <= pin.point_x;
          cur_y <= pin.point_y;
          last  <= pin.final_point;
          r_hit <= 1'b0;
          if (!have_prev || pin.first_point) begin
            seg_cnt <= '0;
            go      <= 1'b0;
          end else begin
            idx     <= 16'(seg_cnt);
            go      <= 1'b1;
            seg_cnt <= (cnt_inc >= (SC+1)'(MAX_SEGMENTS)) ? '0 : seg_cnt + 1'b1;
          end
          state <= S_BOX;
        end
        S_BOX: begin
          vq <= vqa;
          if (!go || box_miss) state <= S_OUT;
          else if (vqa) begin
            if (vb) begin
              n <= W'(lo) - W'(34'(prev_y));
              d <= W'(dyb);
              if (!(lo < hi)) state <= S_OUT;
              else state <= S_CHK;
            end else begin
              n <= W'(dqx);
              d <= W'(dxb);
              state <= S_CHK;
            end
          end else begin
            m_start <= 1'b1;
            state <= S_M0;
          end
        end
        S_M0: if (m_done) begin p0 <= W'(m_prod); m_start <= 1'b1; state <= S_M1; end
        S_M1: if (m_done) begin n <= p0 - W'(m_prod); m_start <= 1'b1; state <= S_M2; end
        S_M2: if (m_done) begin p0 <= W'(m_prod); m_start <= 1'b1; state <= S_M3; end
        S_M3: if (m_done) begin d <= p0 - W'(m_prod); m_start <= 1'b1; state <= S_M4; end
        S_M4: if (m_done) begin p0 <= W'(m_prod); m_start <= 1'b1; state <= S_M5; end
        S_M5: if (m_done) begin t <= p0 - W'(m_prod); state <= S_CHK; end
        S_CHK: begin
          if (in_unit(n, d) && (vq || in_unit(t, d))) begin
            dv_start <= 1'b1;
            state <= S_DIV;
          end else state <= S_OUT;
        end
        S_DIV: if (dv_done) begin
          m_start <= 1'b1;
          state <= S_SX;
        end
        S_SX: if (m_done) begin
          r_cx <= 32'(68'(prev_x) + sc);
          m_start <= 1'b1;
          state <= S_SY;
        end
        S_SY: if (m_done) begin
          r_cy  <= 32'(68'(prev_y) + sc);
          r_hit <= 1'b1;
          if (QB >= 16) r_frac <= 17'(q >> (QB - 16));
          else r_frac <= 17'(q) << (16 - QB);
          state <= S_OUT;
        end
        S_OUT: begin
          prev_x <= cur_x;
          prev_y <= cur_y;
          have_prev <= !last;
          if (r_hit || last) r_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rout.hit           = r_hit;
  assign rout.segment_index = r_hit ? idx : '0;
  assign rout.fraction      = r_hit ? r_frac : '0;
  assign rout.cross_x       = r_hit ? r_cx : '0;
  assign rout.cross_y       = r_hit ? r_cy : '0;
  assign rout.list_end      = last;
endmodule

// ===== tb/polyline_line_intersection_tb.sv =====
// testbench for the polyline against query segment intersection block
module polyline_line_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;

  localparam int MaxErrShown = 10;
  localparam longint CycleLimit = 4000000;
  localparam int FracBits = 16;

  logic clk;
  logic rst;
  pli_cfg_if    cfg();
  pli_point_if  pin();
  pli_result_if rout();

  polyline_line_intersection dut (.clk(clk), .rst(rst), .cfg(cfg), .pin(pin), .rout(rout));

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor state
  longint qsx, qsy, qex, qey;
  longint prev_x, prev_y;
  bit have_prev;
  int unsigned seg_count;

  result_t pending_hits[$];
  int mismatches;
  longint cycles;
  int rx_min, rx_max;
  int rx_wait;

  function automatic longint min2(longint a, longint b);
    return a < b ? a : b;
  endfunction
  function automatic longint max2(longint a, longint b);
    return a > b ? a : b;
  endfunction
  function automatic longint absl(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic bit in_unit(logic signed [69:0] n, logic signed [69:0] d);
    if (d == 0) return 0;
    if (n == 0) return 1;
    if ((n < 0) != (d < 0)) return 0;
    return (n < 0 ? -n : n) <= (d < 0 ? -d : d);
  endfunction

  function automatic bit segment_hits(longint x0b, longint y0b, longint x1b, longint y1b,
                                      output longint unsigned q);
    logic signed [69:0] n, d, t;
    logic [89:0] an, ad;
    longint lo, hi, dxa, dya, dxb, dyb, ex, ey;
    q = 0;
    if (min2(x0b, x1b) > max2(qsx, qex) || max2(x0b, x1b) < min2(qsx, qex) ||
        min2(y0b, y1b) > max2(qsy, qey) || max2(y0b, y1b) < min2(qsy, qey))
      return 0;
    if (absl(qsx - qex) < 7) begin
      if (absl(x1b - x0b) < 7) begin
        lo = max2(min2(qsy, qey), min2(y0b, y1b));
        hi = min2(max2(qsy, qey), max2(y0b, y1b));
        if (!(lo < hi)) return 0;
        n = lo - y0b;
        d = y1b - y0b;
      end else begin
        n = qsx - x0b;
        d = x1b - x0b;
      end
      if (!in_unit(n, d)) return 0;
    end else begin
      dxa = qex - qsx; dya = qey - qsy;
      dxb = x1b - x0b; dyb = y1b - y0b;
      ex = x0b - qsx;  ey = y0b - qsy;
      n = 70'(ex) * 70'(dya) - 70'(ey) * 70'(dxa);
      d = 70'(dxa) * 70'(dyb) - 70'(dya) * 70'(dxb);
      if (!in_unit(n, d)) return 0;
      t = 70'(ex) * 70'(dyb) - 70'(ey) * 70'(dxb);
      if (!in_unit(t, d)) return 0;
    end
    an = n < 0 ? 90'(-n) : 90'(n);
    ad = d < 0 ? 90'(-d) : 90'(d);
    q = longint'((an << FracBits) / ad);
    return 1;
  endfunction

  function automatic longint scale_delta(longint delta, longint unsigned q);
    longint p;
    p = delta * longint'(q);
    if (p >= 0) return p >>> FracBits;
    return -((-p + (64'd1 << FracBits) - 1) >>> FracBits);
  endfunction

  task automatic predict_vertex(logic signed [31:0] px, logic signed [31:0] py,
                                bit first, bit last);
    result_t r;
    longint unsigned q;
    bit hit;
    int unsigned idx;
    hit = 0;
    idx = 0;
    r = '0;
    if (!have_prev || first) begin
      seg_count = 0;
    end else begin
      idx = seg_count;
      if (segment_hits(prev_x, prev_y, px, py, q)) begin
        hit = 1;
        r.cross_x = 32'(prev_x + scale_delta(longint'(px) - prev_x, q));
        r.cross_y = 32'(prev_y + scale_delta(longint'(py) - prev_y, q));
        r.fraction = 17'(q);
        r.segment_index = 16'(idx);
      end
      seg_count = (seg_count + 1 >= 65536) ? 0 : seg_count + 1;
    end
    prev_x = px;
    prev_y = py;
    have_prev = !last;
    r.hit = hit;
    r.list_end = last;
    if (hit || last) pending_hits = {pending_hits, r};
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_QSX: qsx = longint'(signed'(val));
      REG_QSY: qsy = longint'(signed'(val));
      REG_QEX: qex = longint'(signed'(val));
      default: qey = longint'(signed'(val));
    endcase
  endtask

  task automatic set_query(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1, logic [31:0] y1);
    write_reg(REG_QSX, x0);
    write_reg(REG_QSY, y0);
    write_reg(REG_QEX, x1);
    write_reg(REG_QEY, y1);
    cfg.valid <= 1'b0;
  endtask

  task automatic hold_input();
    pin.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    hold_input();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic send_vertex(logic [31:0] px, logic [31:0] py, bit first, bit last);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      pin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pin.valid <= 1'b1;
    pin.point_x <= px;
    pin.point_y <= py;
    pin.first_point <= first;
    pin.final_point <= last;
    @(posedge clk);
    while (!pin.ready) @(posedge clk);
    predict_vertex(px, py, first, last);
  endtask

  // receiver side
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      rout.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (rout.valid && rout.ready) begin
        got = '{rout.hit, rout.segment_index, rout.fraction, rout.cross_x, rout.cross_y,
                rout.list_end};
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxErrShown) $display("unexpected result beat %p", got);
        end else begin
          want = pending_hits.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxErrShown) $display("mismatch: expected %p got %p", want, got);
          end
        end
        rx_wait = $urandom_range(rx_min, rx_max);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      rout.ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    bit first;
    bit last;
    bit check;
    result_t res;
  } vec_row_t;

  vec_row_t dir_rows[$];

  function automatic result_t no_hit_end();
    result_t r;
    r = '0;
    r.list_end = 1'b1;
    return r;
  endfunction

  function automatic vec_row_t row(logic [31:0] x, logic [31:0] y, bit f, bit l);
    vec_row_t v;
    v.px = x; v.py = y; v.first = f; v.last = l; v.check = 0; v.res = '0;
    return v;
  endfunction

  function automatic void add_row(vec_row_t v);
    dir_rows = {dir_rows, v};
  endfunction

  task automatic run_rows();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].check) begin
        send_vertex(dir_rows[i].px, dir_rows[i].py, dir_rows[i].first, dir_rows[i].last);
        if (pending_hits.size() == 0 || pending_hits[$] != dir_rows[i].res) begin
          mismatches++;
          if (mismatches <= MaxErrShown) $display("directed row %0d predicts wrongly", i);
        end
      end else begin
        send_vertex(dir_rows[i].px, dir_rows[i].py, dir_rows[i].first, dir_rows[i].last);
      end
    end
    dir_rows.delete();
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return 32'($signed($urandom_range(0, 24)) - 12);
    endcase
  endfunction

  initial begin
    vec_row_t v;
    int mode, len;
    logic [31:0] cx;
    rst = 1'b1;
    mismatches = 0;
    cycles = 0;
    rx_min = 0; rx_max = 0;
    cfg.valid = 1'b0; cfg.index = REG_QSX; cfg.data = '0;
    pin.valid = 1'b0; pin.point_x = '0; pin.point_y = '0;
    pin.first_point = 1'b0; pin.final_point = 1'b0;
    qsx = 0; qsy = 0; qex = 0; qey = 0;
    prev_x = 0; prev_y = 0; have_prev = 0; seg_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: query at reset is the origin point
    v = row(32'd0, 32'd0, 1, 1); v.check = 1; v.res = no_hit_end(); add_row(v);
    add_row(row(32'h8000_0000, 32'h7fff_ffff, 0, 0));
    add_row(row(32'h7fff_ffff, 32'h8000_0000, 0, 1));
    run_rows();
    drain_results();

    // general case: diagonal query
    set_query(32'hfffe_0000, 32'hfffe_0000, 32'h0002_0000, 32'h0002_0000);
    add_row(row(32'hfffe_0000, 32'h0002_0000, 1, 0));
    add_row(row(32'h0002_0000, 32'hfffe_0000, 0, 0));
    add_row(row(32'h0005_0000, 32'h0005_0000, 0, 0));
    add_row(row(32'h0000_0000, 32'h0000_0000, 0, 0));
    add_row(row(32'h0001_0000, 32'h0001_0000, 0, 1));
    // missing first point after final
    add_row(row(32'h0000_0000, 32'h0003_0000, 0, 0));
    add_row(row(32'h0000_0000, 32'hfffd_0000, 0, 1));
    run_rows();
    drain_results();

    // vertical query against vertical and sloped segments
    set_query(32'h0001_0000, 32'hffff_0000, 32'h0001_0003, 32'h0003_0000);
    add_row(row(32'h0001_0002, 32'h0002_0000, 1, 0));
    add_row(row(32'h0001_0000, 32'hfffc_0000, 0, 0));
    add_row(row(32'h0001_0000, 32'hfff0_0000, 0, 0));
    add_row(row(32'h0000_0000, 32'h0000_0000, 0, 0));
    add_row(row(32'h0003_0000, 32'h0001_0000, 0, 0));
    add_row(row(32'h0001_0006, 32'h0001_0000, 0, 1));
    run_rows();
    drain_results();

    // extreme query registers
    set_query(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_row(row(32'h8000_0000, 32'h7fff_ffff, 1, 0));
    add_row(row(32'h7fff_ffff, 32'h8000_0000, 0, 0));
    add_row(row(32'h0000_0000, 32'h0000_0000, 0, 0));
    add_row(row(32'h0000_0000, 32'h0000_0000, 0, 1));
    run_rows();
    drain_results();

    // random phases
    for (int phase = 0; phase < 8; phase++) begin
      mode = phase % 3;
      case (phase)
        0: set_query(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        3: begin
          cx = rand_coord(1);
          set_query(cx, rand_coord(1), cx + 32'($urandom_range(0, 6)), rand_coord(1));
        end
        default: set_query(rand_coord(mode == 0 ? 1 : mode), rand_coord(mode == 0 ? 1 : mode),
                           rand_coord(mode == 0 ? 1 : mode), rand_coord(mode == 0 ? 1 : mode));
      endcase
      case (phase % 4)
        0: begin rx_min = 0; rx_max = 0; end
        1: begin rx_min = 0; rx_max = 13; end
        2: begin rx_min = 0; rx_max = 2; end
        default: begin rx_min = 1; rx_max = 1; end
      endcase
      for (int k = 0; k < 100; k += len) begin
        len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          send_vertex(rand_coord(($urandom_range(0, 7) == 0) ? 0 : (phase == 3 ? 1 : mode)),
                      rand_coord(($urandom_range(0, 7) == 0) ? 0 : (phase == 3 ? 1 : mode)),
                      j == 0 ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                      j == len - 1 ? ($urandom_range(0, 9) != 0) : 1'b0);
        end
        if (phase == 2 && k == 0) begin
          hold_input();
          while (pending_hits.size() != 0) @(posedge clk);
        end
      end
      rx_min = 0; rx_max = 1;
      drain_results();
    end

    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/pli_pkg.sv
hw/rtl/pli_if.sv
hw/rtl/pli_mul.sv
hw/rtl/pli_div.sv
hw/rtl/polyline_line_intersection.sv
tb/polyline_line_intersection_tb.sv
